// File: src/irpd_pkg.sv
// Package for the IR-controlled phase dimmer: command and register codes,
// reset values and NEC timing windows. No dependencies.

package irpd_pkg;

    localparam int CODE_BITS_DEF = 32;

    localparam int DELAY_W = 14;
    localparam int PW_W    = 8;
    localparam int WORD_W  = 32;
    localparam int CMD_W   = 2;
    localparam int ADDR_W  = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_IR_EDGE    = 2'd0,
        CMD_ZERO_CROSS = 2'd1,
        CMD_POLL       = 2'd2
    } t_cmd;

    typedef enum logic [ADDR_W-1:0] {
        REG_STEP      = 4'd0,
        REG_MIN_DELAY = 4'd1,
        REG_MAX_DELAY = 4'd2,
        REG_PULSE_W   = 4'd3,
        REG_UP_A      = 4'd4,
        REG_UP_B      = 4'd5,
        REG_DOWN_A    = 4'd6,
        REG_DOWN_B    = 4'd7
    } t_reg_idx;

    localparam logic [DELAY_W-1:0] STEP_RST      = 14'd900;
    localparam logic [DELAY_W-1:0] MIN_DELAY_RST = 14'd96;
    localparam logic [DELAY_W-1:0] MAX_DELAY_RST = 14'd9980;
    localparam logic [PW_W-1:0]    PULSE_W_RST   = 8'd25;
    localparam logic [WORD_W-1:0]  UP_A_RST      = 32'h01FE_50AF;
    localparam logic [WORD_W-1:0]  UP_B_RST      = 32'h00FF_2857;
    localparam logic [WORD_W-1:0]  DOWN_A_RST    = 32'h01FE_D827;
    localparam logic [WORD_W-1:0]  DOWN_B_RST    = 32'h00FF_6C13;
    localparam logic [DELAY_W-1:0] DELAY_RST     = 14'd5120;

    // Interval windows in microseconds (16-bit interval)
    localparam logic [15:0] HDR_MIN   = 16'd9000;
    localparam logic [15:0] HDR_MAX   = 16'd9500;
    localparam logic [15:0] MARK_MIN  = 16'd500;
    localparam logic [15:0] MARK_MAX  = 16'd700;
    localparam logic [15:0] ZERO_MIN  = 16'd400;
    localparam logic [15:0] ZERO_MAX  = 16'd700;
    localparam logic [15:0] ONE_MIN   = 16'd1400;
    localparam logic [15:0] ONE_MAX   = 16'd1900;

endpackage

// File: src/ir_controlled_phase_dimmer.sv
// IR-controlled phase dimmer top level: NEC pulse decoder, delay stepping
// and triac gate timing. Depends on irpd_pkg.

// The block takes one timestamped event per beat (tuser = event kind, tdata =
// microsecond timestamp) and returns exactly one result beat for it in the
// cycle after it is accepted, from a single output register. An event is
// accepted in every cycle in which that output register is empty or being
// drained, so the sustained rate is one event per clock; the only thing that
// holds input is a stalled output register. All decode, delay and gate work for
// an event is combinational between the state registers and the output register.
// Configuration writes are taken every cycle (o_cfg_ready is always high) and
// must only be issued while no event is in flight.

module ir_controlled_phase_dimmer #(
    parameter int CODE_BITS = irpd_pkg::CODE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration write channel
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [irpd_pkg::ADDR_W-1:0]  i_cfg_addr,
    input  logic [irpd_pkg::WORD_W-1:0]  i_cfg_data,
    // event stream in
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [31:0]                  s_axis_tdata,   // [31:0] now_us
    input  logic [irpd_pkg::CMD_W-1:0]   s_axis_tuser,   // [1:0] cmd
    // result stream out
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [47:0]                  m_axis_tdata,   // [0] gate_on, [32:1] code,
                                                         // [46:33] delay_us, [47] zero
    output logic                         m_axis_tuser    // [0] code_done
);
    import irpd_pkg::*;

    localparam int CNT_W = $clog2(CODE_BITS + 1);

    // configuration
    logic [DELAY_W-1:0] r_step, r_min_delay, r_max_delay;
    logic [PW_W-1:0]    r_pulse_w;
    logic [WORD_W-1:0]  r_up_a, r_up_b, r_down_a, r_down_b;

    // state
    logic [15:0]          r_last_edge, n_last_edge;
    logic                 r_in_bit_half, n_in_bit_half;
    logic [CODE_BITS-1:0] r_shift, n_shift;
    logic [CNT_W-1:0]     r_bit_count, n_bit_count;
    logic [DELAY_W-1:0]   r_delay, n_delay;
    logic                 r_pending, n_pending;
    logic [31:0]          r_stamp, n_stamp;
    logic                 r_gate, n_gate;

    // output register
    logic                 r_out_valid;
    logic                 r_out_done, n_out_done;
    logic [WORD_W-1:0]    r_out_code, n_out_code;
    logic                 r_out_gate;
    logic [DELAY_W-1:0]   r_out_delay;

    logic w_accept;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= STEP_RST;
            r_min_delay <= MIN_DELAY_RST;
            r_max_delay <= MAX_DELAY_RST;
            r_pulse_w   <= PULSE_W_RST;
            r_up_a      <= UP_A_RST;
            r_up_b      <= UP_B_RST;
            r_down_a    <= DOWN_A_RST;
            r_down_b    <= DOWN_B_RST;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_addr))
                REG_STEP:      r_step      <= i_cfg_data[DELAY_W-1:0];
                REG_MIN_DELAY: r_min_delay <= i_cfg_data[DELAY_W-1:0];
                REG_MAX_DELAY: r_max_delay <= i_cfg_data[DELAY_W-1:0];
                REG_PULSE_W:   r_pulse_w   <= i_cfg_data[PW_W-1:0];
                REG_UP_A:      r_up_a      <= i_cfg_data;
                REG_UP_B:      r_up_b      <= i_cfg_data;
                REG_DOWN_A:    r_down_a    <= i_cfg_data;
                REG_DOWN_B:    r_down_b    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin : next_state
        logic [15:0]       v_d;
        logic [WORD_W-1:0] v_word;
        logic [DELAY_W:0]  v_adj;
        logic [31:0]       v_elapsed;
        logic [31:0]       v_gate_end;

        n_last_edge   = r_last_edge;
        n_in_bit_half = r_in_bit_half;
        n_shift       = r_shift;
        n_bit_count   = r_bit_count;
        n_delay       = r_delay;
        n_pending     = r_pending;
        n_stamp       = r_stamp;
        n_gate        = r_gate;
        n_out_done    = 1'b0;
        n_out_code    = '0;

        v_d        = s_axis_tdata[15:0] - r_last_edge;
        v_word     = '0;
        v_adj      = {1'b0, r_delay};
        v_elapsed  = s_axis_tdata - r_stamp;
        v_gate_end = 32'({1'b0, r_delay} + {{(DELAY_W+1-PW_W){1'b0}}, r_pulse_w});

        if (w_accept) begin
            case (t_cmd'(s_axis_tuser))
                CMD_IR_EDGE: begin
                    n_last_edge = s_axis_tdata[15:0];
                    if (!r_in_bit_half) begin
                        if (v_d inside {[HDR_MIN:HDR_MAX]}) begin
                            n_bit_count = '0;
                            n_shift     = '0;
                        end else if (v_d inside {[MARK_MIN:MARK_MAX]}) begin
                            n_in_bit_half = 1'b1;
                        end
                    end else begin
                        n_in_bit_half = 1'b0;
                        if (v_d inside {[ZERO_MIN:ZERO_MAX]}) begin
                            n_shift = {r_shift[CODE_BITS-2:0], 1'b0};
                        end else if (v_d inside {[ONE_MIN:ONE_MAX]}) begin
                            n_shift = {r_shift[CODE_BITS-2:0], 1'b1};
                        end
                        n_bit_count = r_bit_count + 1'b1;
                    end
                    if (n_bit_count >= CNT_W'(CODE_BITS)) begin
                        v_word = WORD_W'(n_shift);
                        // step, saturating at zero on the way down
                        if (v_word == r_up_a || v_word == r_up_b) begin
                            v_adj = {1'b0, r_delay} + {1'b0, r_step};
                        end else if (v_word == r_down_a || v_word == r_down_b) begin
                            v_adj = (r_delay < r_step) ? '0 : {1'b0, r_delay - r_step};
                        end
                        if (v_adj < {1'b0, r_min_delay}) begin
                            n_delay = r_min_delay;
                        end else if (v_adj > {1'b0, r_max_delay}) begin
                            n_delay = r_max_delay;
                        end else begin
                            n_delay = v_adj[DELAY_W-1:0];
                        end
                        n_bit_count = '0;
                        n_shift     = '0;
                        n_out_done  = 1'b1;
                        n_out_code  = v_word;
                    end
                end
                CMD_ZERO_CROSS: begin
                    n_stamp   = s_axis_tdata;
                    n_pending = 1'b1;
                end
                CMD_POLL: begin
                    if (r_pending && (32'(r_delay) < v_elapsed)) begin
                        n_gate = 1'b1;
                        if (v_gate_end < v_elapsed) begin
                            n_gate    = 1'b0;
                            n_pending = 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_edge   <= '0;
            r_in_bit_half <= 1'b0;
            r_shift       <= '0;
            r_bit_count   <= '0;
            r_delay       <= DELAY_RST;
            r_pending     <= 1'b0;
            r_stamp       <= '0;
            r_gate        <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_last_edge   <= n_last_edge;
            r_in_bit_half <= n_in_bit_half;
            r_shift       <= n_shift;
            r_bit_count   <= n_bit_count;
            r_delay       <= n_delay;
            r_pending     <= n_pending;
            r_stamp       <= n_stamp;
            r_gate        <= n_gate;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded with each accepted beat
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_done  <= n_out_done;
            r_out_code  <= n_out_code;
            r_out_gate  <= n_gate;
            r_out_delay <= n_delay;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_done;
    assign m_axis_tdata  = {1'b0, r_out_delay, r_out_code, r_out_gate};

    // gate can only be high inside a pending crossing window
    a_gate_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gate |-> r_pending)
        else $error("gate high without pending crossing");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_count < CNT_W'(CODE_BITS))
        else $error("bit count reached code length without completing");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while result stalled");

    a_crossing_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && s_axis_tuser == CMD_ZERO_CROSS) |=> r_pending)
        else $error("zero crossing did not arm gate timing");

endmodule

// File: test/tb_ir_controlled_phase_dimmer.sv
// Self-checking testbench for ir_controlled_phase_dimmer: NEC frames, zero-crossing
// and poll sequences and noise against an in-bench predictor, with random stalls.
// Depends on irpd_pkg and the ir_controlled_phase_dimmer RTL.

module tb_ir_controlled_phase_dimmer;
    timeunit 1ns;
    timeprecision 1ps;

    import irpd_pkg::*;

    localparam logic [CMD_W-1:0]  CMD_SPARE       = 2'd3;
    localparam logic [ADDR_W-1:0] REG_SPARE_FIRST = 4'd8;
    localparam logic [ADDR_W-1:0] REG_SPARE_LAST  = 4'd15;
    localparam int DELAY_MAX      = 16383;
    localparam int PULSE_MAX      = 255;
    localparam int TARGET_EVENTS  = 1100;
    localparam int PHASE_EVENTS   = 150;
    localparam int HOLD_CYCLES    = 64;
    localparam int SETTLE_CYCLES  = 3;
    localparam int QUIET_LIMIT    = 1000;
    localparam int MAX_REPORTS    = 10;

    typedef struct {
        logic                gate_on;
        logic                code_done;
        logic [WORD_W-1:0]   code;
        logic [DELAY_W-1:0]  delay_us;
    } t_dimmer_out;

    // Predictor of the dimmer plus the queue of outputs it still owes.
    class dimmer_scoreboard;
        logic [DELAY_W-1:0] step, min_delay, max_delay, delay;
        logic [PW_W-1:0]    pulse_w;
        logic [WORD_W-1:0]  up_a, up_b, down_a, down_b;
        logic [31:0]        last_edge, cross_stamp, shift_word;
        logic [5:0]         bit_count;
        logic               bit_half, armed, gate;
        t_dimmer_out        dimmer_outputs_q[$];
        int n_errors, n_checked, n_codes, n_steered, n_pulses;

        function new();
            step = STEP_RST;       min_delay = MIN_DELAY_RST;
            max_delay = MAX_DELAY_RST;  pulse_w = PULSE_W_RST;
            up_a = UP_A_RST;       up_b = UP_B_RST;
            down_a = DOWN_A_RST;   down_b = DOWN_B_RST;
            delay = DELAY_RST;
            last_edge = '0; cross_stamp = '0; shift_word = '0;
            bit_count = '0; bit_half = 1'b0; armed = 1'b0; gate = 1'b0;
            n_errors = 0; n_checked = 0; n_codes = 0; n_steered = 0; n_pulses = 0;
        endfunction

        function void write_reg(logic [ADDR_W-1:0] idx, logic [WORD_W-1:0] data);
            case (idx)
                REG_STEP:      step = data[DELAY_W-1:0];
                REG_MIN_DELAY: min_delay = data[DELAY_W-1:0];
                REG_MAX_DELAY: max_delay = data[DELAY_W-1:0];
                REG_PULSE_W:   pulse_w = data[PW_W-1:0];
                REG_UP_A:      up_a = data;
                REG_UP_B:      up_b = data;
                REG_DOWN_A:    down_a = data;
                REG_DOWN_B:    down_b = data;
                default: ;
            endcase
        endfunction

        function void note_event(logic [CMD_W-1:0] kind, logic [31:0] stamp);
            t_dimmer_out  want;
            logic [15:0]  gap;
            logic [31:0]  elapsed;
            int unsigned  d;
            want.code_done = 1'b0;
            want.code = '0;
            if (kind == CMD_IR_EDGE) begin
                gap = 16'(stamp - last_edge);
                last_edge = stamp;
                if (!bit_half) begin
                    if (gap >= HDR_MIN && gap <= HDR_MAX) begin
                        bit_count = '0;
                        shift_word = '0;
                    end else if (gap >= MARK_MIN && gap <= MARK_MAX) begin
                        bit_half = 1'b1;
                    end
                end else begin
                    bit_half = 1'b0;
                    if (gap >= ZERO_MIN && gap <= ZERO_MAX)
                        shift_word = shift_word << 1;
                    else if (gap >= ONE_MIN && gap <= ONE_MAX)
                        shift_word = {shift_word[30:0], 1'b1};
                    bit_count = bit_count + 6'd1;
                end
                if (bit_count >= CODE_BITS_DEF) begin
                    bit_count = '0;
                    want.code_done = 1'b1;
                    want.code = shift_word;
                    n_codes++;
                    // up codes take priority; down saturates at zero before the clamp
                    d = delay;
                    if (shift_word == up_a || shift_word == up_b) begin
                        d = d + step;
                        n_steered++;
                    end else if (shift_word == down_a || shift_word == down_b) begin
                        d = (d < step) ? 0 : d - step;
                        n_steered++;
                    end
                    if (d < min_delay)
                        d = min_delay;
                    else if (d > max_delay)
                        d = max_delay;
                    delay = DELAY_W'(d);
                    shift_word = '0;
                end
            end else if (kind == CMD_ZERO_CROSS) begin
                cross_stamp = stamp;
                armed = 1'b1;
            end else if (kind == CMD_POLL && armed) begin
                elapsed = stamp - cross_stamp;
                if (32'(delay) < elapsed) begin
                    gate = 1'b1;
                    if (32'(delay) + 32'(pulse_w) < elapsed) begin
                        gate = 1'b0;
                        armed = 1'b0;
                        n_pulses++;
                    end
                end
            end
            want.gate_on = gate;
            want.delay_us = delay;
            dimmer_outputs_q.push_back(want);
        endfunction

        function void check_output(logic [47:0] data, logic user);
            t_dimmer_out want;
            bit          bad;
            n_checked++;
            if (dimmer_outputs_q.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("ERROR: unexpected result beat tdata=%h tuser=%b", data, user);
                return;
            end
            want = dimmer_outputs_q.pop_front();
            bad = (data[0] !== want.gate_on) || (user !== want.code_done) ||
                  (data[32:1] !== want.code) || (data[46:33] !== want.delay_us) ||
                  (data[47] !== 1'b0);
            if (bad) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS) begin
                    $write("ERROR: beat %0d exp/act gate %b/%b done %b/%b ",
                           n_checked, want.gate_on, data[0], want.code_done, user);
                    $display("code %h/%h delay %0d/%0d pad 0/%b",
                             want.code, data[32:1], want.delay_us, data[46:33], data[47]);
                end
            end
        endfunction

        function int outstanding();
            return dimmer_outputs_q.size();
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [ADDR_W-1:0]  i_cfg_addr = '0;
    logic [WORD_W-1:0]  i_cfg_data = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [31:0]        s_axis_tdata = '0;      // [31:0] now_us
    logic [CMD_W-1:0]   s_axis_tuser = '0;      // [1:0] cmd
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [47:0]        m_axis_tdata;           // [0] gate_on, [32:1] code, [46:33] delay_us
    logic               m_axis_tuser;           // [0] code_done

    dimmer_scoreboard sb;
    int          gap_max = 10;
    int          stall_max = 10;
    bit          hold_req = 1'b0;
    int          events_sent = 0;
    int          settings_run = 1;
    logic [31:0] t_now;

    ir_controlled_phase_dimmer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    task automatic push_event(input logic [CMD_W-1:0] kind, input logic [31:0] stamp);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= stamp;
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        sb.note_event(kind, stamp);
        events_sent++;
    endtask

    // Interval as seen by the decoder is mod 2^16, so extra 64k multiples must not matter
    task automatic push_edge(input int unsigned interval);
        t_now = t_now + interval;
        if ($urandom_range(0, 7) == 0)
            t_now = t_now + ($urandom_range(1, 3) << 16);
        push_event(CMD_IR_EDGE, t_now);
    endtask

    task automatic send_frame(input logic [WORD_W-1:0] word, input bit corrupt);
        int bad_at;
        int unsigned iv;
        // a dangling half bit would eat the header as a data bit
        if (sb.bit_half)
            push_edge(3000);
        bad_at = corrupt ? $urandom_range(0, 64) : -1;
        for (int k = 0; k <= 64; k++) begin
            if (k == 0)
                iv = $urandom_range(HDR_MIN, HDR_MAX);
            else if (k % 2 == 1)
                iv = $urandom_range(MARK_MIN, MARK_MAX);
            else if (word[WORD_W - k / 2])
                iv = $urandom_range(ONE_MIN, ONE_MAX);
            else
                iv = $urandom_range(ZERO_MIN, ZERO_MAX);
            if (k == bad_at)
                iv = $urandom_range(0, 12000);
            push_edge(iv);
        end
    endtask

    // Zero crossing, then polls around the firing and release thresholds
    task automatic gate_seq(input int unsigned lead, input bit full);
        logic [31:0] base;
        int unsigned d, pw;
        int unsigned marks[6];
        t_now = t_now + lead;
        push_event(CMD_ZERO_CROSS, t_now);
        base = t_now;
        d = sb.delay;
        pw = sb.pulse_w;
        marks = '{(d > 0) ? d - 1 : 0, d, d + 1, d + pw, d + pw + 1,
                  d + pw + 2 + $urandom_range(0, 500)};
        foreach (marks[i]) begin
            if (full || $urandom_range(0, 9) < 7) begin
                t_now = base + marks[i];
                push_event(CMD_POLL, t_now);
            end
        end
    endtask

    task automatic noise_burst();
        int n;
        n = $urandom_range(1, 6);
        repeat (n) begin
            t_now = ($urandom_range(0, 3) == 0) ? $urandom() : t_now + $urandom_range(0, 2000);
            push_event(CMD_W'($urandom_range(0, 3)), t_now);
        end
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.outstanding() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [ADDR_W-1:0] addr, input logic [WORD_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        sb.write_reg(addr, data);
    endtask

    // Upper bits of the narrow registers get junk; the block must ignore it
    task automatic load_setting(input int phase);
        logic [WORD_W-1:0] twin;
        twin = $urandom();
        case (phase)
            1: begin
                cfg_write(REG_STEP,      {18'($urandom()), 14'($urandom_range(0, DELAY_MAX))});
                cfg_write(REG_MIN_DELAY, {18'($urandom()), 14'($urandom_range(0, DELAY_MAX))});
                cfg_write(REG_MAX_DELAY, {18'($urandom()), 14'($urandom_range(0, DELAY_MAX))});
                cfg_write(REG_PULSE_W,   {24'($urandom()), 8'($urandom_range(0, PULSE_MAX))});
                cfg_write(REG_UP_A,   $urandom());
                cfg_write(REG_UP_B,   $urandom());
                cfg_write(REG_DOWN_A, $urandom());
                cfg_write(REG_DOWN_B, $urandom());
            end
            2: begin
                cfg_write(REG_STEP,      {18'($urandom()), 14'(DELAY_MAX)});
                cfg_write(REG_MIN_DELAY, {18'($urandom()), 14'(0)});
                cfg_write(REG_MAX_DELAY, {18'($urandom()), 14'(DELAY_MAX)});
                cfg_write(REG_PULSE_W,   {24'($urandom()), 8'(PULSE_MAX)});
            end
            3: begin
                cfg_write(REG_STEP,      {18'($urandom()), 14'(0)});
                cfg_write(REG_MIN_DELAY, {18'($urandom()), 14'(0)});
                cfg_write(REG_MAX_DELAY, {18'($urandom()), 14'(0)});
                cfg_write(REG_PULSE_W,   {24'($urandom()), 8'(0)});
            end
            4: begin
                // min above max
                cfg_write(REG_STEP,      {18'($urandom()), 14'($urandom_range(1, 3000))});
                cfg_write(REG_MIN_DELAY, {18'($urandom()), 14'($urandom_range(9000, DELAY_MAX))});
                cfg_write(REG_MAX_DELAY, {18'($urandom()), 14'($urandom_range(0, 8999))});
                cfg_write(REG_PULSE_W,   {24'($urandom()), 8'($urandom_range(0, PULSE_MAX))});
            end
            5: begin
                // same word as up and down code; huge step drives downs to zero
                cfg_write(REG_UP_A,   twin);
                cfg_write(REG_DOWN_A, twin);
                cfg_write(REG_UP_B,   $urandom());
                cfg_write(REG_DOWN_B, $urandom());
                cfg_write(REG_STEP,      {18'($urandom()), 14'(DELAY_MAX)});
                cfg_write(REG_MIN_DELAY, {18'($urandom()), 14'(0)});
                cfg_write(REG_MAX_DELAY, {18'($urandom()), 14'($urandom_range(1000, DELAY_MAX))});
            end
            6: begin
                cfg_write(ADDR_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), $urandom());
                cfg_write(REG_STEP,      {18'($urandom()), 14'($urandom_range(1, 400))});
                cfg_write(REG_MIN_DELAY, {18'($urandom()), 14'($urandom_range(0, 2000))});
                cfg_write(REG_MAX_DELAY, {18'($urandom()), 14'($urandom_range(2000, DELAY_MAX))});
                cfg_write(REG_UP_A,   UP_A_RST);
                cfg_write(REG_UP_B,   UP_B_RST);
                cfg_write(REG_DOWN_A, DOWN_A_RST);
                cfg_write(REG_DOWN_B, DOWN_B_RST);
            end
            default: begin
                cfg_write(REG_STEP,      {18'($urandom()), 14'($urandom_range(0, 2000))});
                cfg_write(REG_MIN_DELAY, {18'($urandom()), 14'($urandom_range(0, 4000))});
                cfg_write(REG_MAX_DELAY, {18'($urandom()), 14'($urandom_range(0, DELAY_MAX))});
                cfg_write(REG_PULSE_W,   {24'($urandom()), 8'($urandom_range(0, PULSE_MAX))});
                if ($urandom_range(0, 1)) cfg_write(REG_UP_A, $urandom());
                if ($urandom_range(0, 1)) cfg_write(REG_DOWN_B, $urandom());
            end
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Result side: random stall per beat, one long hold-off on request
    initial begin : result_sink
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = hold_req ? HOLD_CYCLES : $urandom_range(0, stall_max);
            hold_req = 1'b0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
            sb.check_output(m_axis_tdata, m_axis_tuser);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (!i_rst_n) @(posedge i_clk);
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("ERROR: no handshake for %0d cycles", QUIET_LIMIT);
        $display("tb_ir_controlled_phase_dimmer NOT OK");
        $finish;
    end

    initial begin : stimulus
        int  phase, phase_start, pick;
        bit  hold_done;
        int unsigned win_gaps[17];
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: spare command, idle poll, gate timing across the 32-bit wrap,
        // then every decode window edge
        push_event(CMD_SPARE, 32'hFFFF_FFFF);
        push_event(CMD_POLL, 32'h0000_0000);
        t_now = 32'hFFFF_FF00;
        gate_seq(16, 1'b1);
        push_event(CMD_IR_EDGE, t_now);
        win_gaps = '{8999, 9000, 9500, 9501, 500, 399, 500, 400, 700, 700, 500, 1400,
                     500, 1900, 500, 1901, 701};
        foreach (win_gaps[i])
            push_edge(win_gaps[i]);

        phase = 0;
        hold_done = 1'b0;
        while (events_sent < TARGET_EVENTS) begin
            if (phase > 0) begin
                drain_results();
                load_setting(phase);
                settings_run++;
            end
            gap_max   = (phase % 3 == 2) ? 0 : 10;
            stall_max = (phase % 3 == 2 || phase % 4 == 3) ? 0 : 10;
            phase_start = events_sent;
            while (events_sent - phase_start < PHASE_EVENTS) begin
                if (phase == 1 && !hold_done && events_sent - phase_start > 40) begin
                    hold_req = 1'b1;
                    hold_done = 1'b1;
                end
                pick = $urandom_range(0, 99);
                if (pick < 62) begin
                    case ($urandom_range(0, 5))
                        0: send_frame(sb.up_a, pick >= 50);
                        1: send_frame(sb.up_b, pick >= 50);
                        2: send_frame(sb.down_a, pick >= 50);
                        3: send_frame(sb.down_b, pick >= 50);
                        default: send_frame($urandom(), pick >= 50);
                    endcase
                end else if (pick < 82) begin
                    gate_seq($urandom_range(1, 20000), 1'b0);
                end else begin
                    noise_burst();
                end
            end
            phase++;
        end

        drain_results();
        $display("Covered %0d events over %0d register settings: %0d codes (%0d stepped delay),",
                 events_sent, settings_run, sb.n_codes, sb.n_steered);
        $display("%0d complete gate pulses, %0d result beats checked, %0d mismatches",
                 sb.n_pulses, sb.n_checked, sb.n_errors);
        if (sb.n_errors == 0 && sb.outstanding() == 0)
            $display("tb_ir_controlled_phase_dimmer OK");
        else
            $display("tb_ir_controlled_phase_dimmer NOT OK");
        $finish;
    end

endmodule
